// ===== rtl/core/mea_pkg.sv =====
// Package: shared types, constants and helper functions of the median/average alarm filter.
`default_nettype none

package mea_pkg;

    // Field widths of the channels.
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = SAMPLE_W + 1;

    // Default structural values.
    localparam int WINDOW_DEPTH          = 7;
    localparam int RAISE_CONFIRM         = 5;
    localparam int CLEAR_CONFIRM         = 5;
    localparam int AVERAGE_FRACTION_BITS = 16;

    // Threshold after reset and the hysteresis bounds.
    localparam int THRESHOLD_RESET = 2000;
    localparam int HYST_MIN        = 80;
    localparam int HYST_MAX        = 250;
    localparam int HYST_W          = 9;

    // floor(t * 8 / 100) is computed as (t * HYST_MUL) >> HYST_SHIFT, exact for t < 4096.
    localparam int HYST_MUL   = 10486;
    localparam int HYST_MUL_W = 14;
    localparam int HYST_SHIFT = 17;
    localparam int PROD_W     = SAMPLE_W + HYST_MUL_W;

    typedef logic [SAMPLE_W-1:0]       t_sample;
    typedef logic signed [LEVEL_W-1:0] t_level;

    // Alarm settings handed from the register file to the alarm stage.
    typedef struct packed {
        t_sample threshold;
        t_level  clear_level;
    } t_alarm_cfg;

    // A written threshold of zero is stored as one.
    function automatic t_sample mea_sat_threshold(input t_sample value);
        t_sample res;
        res = (value == '0) ? t_sample'(1) : value;
        return res;
    endfunction

    // Level at or below which the alarm counts towards clearing.
    function automatic t_level mea_clear_level(input t_sample thr);
        logic [PROD_W-1:0] prod;
        logic [HYST_W-1:0] hyst;
        prod = {{HYST_MUL_W{1'b0}}, thr} * PROD_W'(HYST_MUL);
        hyst = prod[HYST_SHIFT +: HYST_W];
        if (hyst < HYST_W'(HYST_MIN)) begin
            hyst = HYST_W'(HYST_MIN);
        end
        if (hyst > HYST_W'(HYST_MAX)) begin
            hyst = HYST_W'(HYST_MAX);
        end
        return $signed({1'b0, thr}) - $signed({{(LEVEL_W - HYST_W){1'b0}}, hyst});
    endfunction

    localparam t_level CLEAR_LEVEL_RESET = mea_clear_level(t_sample'(THRESHOLD_RESET));

endpackage

`default_nettype wire

// ===== rtl/core/mea_if.sv =====
// Interfaces: the sample, result and configuration channels of the filter.
`default_nettype none

interface mea_sample_if;
    logic                    valid;
    logic                    ready;
    logic [mea_pkg::SAMPLE_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface mea_result_if;
    logic                    valid;
    logic                    ready;
    logic [mea_pkg::SAMPLE_W-1:0] filtered_value;
    logic                    alarm_active;
    logic                    alarm_pending;

    modport source (output valid, output filtered_value, output alarm_active,
                    output alarm_pending, input ready);
    modport sink   (input valid, input filtered_value, input alarm_active,
                    input alarm_pending, output ready);
endinterface

interface mea_cfg_if;
    logic                    valid;
    logic                    ready;
    logic [mea_pkg::SAMPLE_W-1:0] alarm_threshold;

    modport source (output valid, output alarm_threshold, input ready);
    modport sink   (input valid, input alarm_threshold, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mea_window.sv =====
// Sample window and rank-based median selection, two pipeline stages.
`default_nettype none

module mea_window #(
    parameter int WINDOW_DEPTH = mea_pkg::WINDOW_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire mea_pkg::t_sample i_sample,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output mea_pkg::t_sample      o_median
);
    import mea_pkg::*;

    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    t_sample         r_win [WINDOW_DEPTH];
    logic [CW-1:0]   r_fill;
    logic            r_win_valid;
    t_sample         r_med;
    logic            r_med_valid;

    logic            med_space;
    logic            med_load;
    logic            accept;
    logic            full;
    logic [CW-1:0]   rank;
    logic [CW-1:0]   lt_cnt [WINDOW_DEPTH];
    logic [CW-1:0]   le_cnt [WINDOW_DEPTH];
    t_sample         n_med;

    // Stage handshakes: the window stage frees when its item moves on.
    assign med_space = !r_med_valid || i_ready;
    assign med_load  = r_win_valid && med_space;
    assign o_ready   = !r_win_valid || med_space;
    assign accept    = i_valid && o_ready;
    assign full      = (r_fill == CW'(WINDOW_DEPTH));

    // Window update: fill in order, then drop the oldest sample.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                if (full) begin
                    r_win[i] <= r_win[i+1];
                end else if (r_fill == CW'(i)) begin
                    r_win[i] <= i_sample;
                end
            end
            if (full || r_fill == CW'(WINDOW_DEPTH - 1)) begin
                r_win[WINDOW_DEPTH-1] <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_win_valid <= 1'b0;
        end else begin
            if (accept && !full) begin
                r_fill <= r_fill + CW'(1);
            end
            if (accept) begin
                r_win_valid <= 1'b1;
            end else if (med_load) begin
                r_win_valid <= 1'b0;
            end
        end
    end

    // Median: each held sample counts how many held samples lie below and at or below it.
    // The one whose span covers position fill/2 is the median; equal candidates share a value.
    always_comb begin
        rank  = r_fill >> 1;
        n_med = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            lt_cnt[i] = '0;
            le_cnt[i] = '0;
            for (int j = 0; j < WINDOW_DEPTH; j++) begin
                if (CW'(j) < r_fill) begin
                    if (r_win[j] < r_win[i]) begin
                        lt_cnt[i] = lt_cnt[i] + CW'(1);
                    end
                    if (r_win[j] <= r_win[i]) begin
                        le_cnt[i] = le_cnt[i] + CW'(1);
                    end
                end
            end
            if (CW'(i) < r_fill && lt_cnt[i] <= rank && rank < le_cnt[i]) begin
                n_med = n_med | r_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (med_load) begin
            r_med <= n_med;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_med_valid <= 1'b0;
        end else if (med_load) begin
            r_med_valid <= 1'b1;
        end else if (i_ready) begin
            r_med_valid <= 1'b0;
        end
    end

    assign o_valid  = r_med_valid;
    assign o_median = r_med;

endmodule

`default_nettype wire

// ===== rtl/core/mea_ema.sv =====
// Exponential average of the median with alpha one quarter, in unsigned fixed point.
`default_nettype none

module mea_ema #(
    parameter int AVERAGE_FRACTION_BITS = mea_pkg::AVERAGE_FRACTION_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire mea_pkg::t_sample i_median,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [mea_pkg::SAMPLE_W+AVERAGE_FRACTION_BITS-1:0] o_avg
);
    import mea_pkg::*;

    localparam int AW = SAMPLE_W + AVERAGE_FRACTION_BITS;
    localparam int SW = AW + 2;

    logic [AW-1:0] r_avg;
    logic          r_seeded;
    logic          r_valid;

    logic          accept;
    logic [AW-1:0] med_fix;
    logic [SW-1:0] sum;
    logic [AW-1:0] n_avg;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Seed with the first median, then avg = floor((3 * avg + median) / 4).
    always_comb begin
        med_fix = {i_median, {AVERAGE_FRACTION_BITS{1'b0}}};
        sum     = {2'b00, r_avg} + {1'b0, r_avg, 1'b0} + {2'b00, med_fix};
        n_avg   = r_seeded ? sum[SW-1:2] : med_fix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg    <= '0;
            r_seeded <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_avg    <= n_avg;
                r_seeded <= 1'b1;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_avg   = r_avg;

endmodule

`default_nettype wire

// ===== rtl/core/mea_alarm.sv =====
// Rounding of the average and the hysteresis alarm, feeding the result register.
`default_nettype none

module mea_alarm #(
    parameter int AVERAGE_FRACTION_BITS = mea_pkg::AVERAGE_FRACTION_BITS,
    parameter int RAISE_CONFIRM         = mea_pkg::RAISE_CONFIRM,
    parameter int CLEAR_CONFIRM         = mea_pkg::CLEAR_CONFIRM
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mea_pkg::t_alarm_cfg i_cfg,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [mea_pkg::SAMPLE_W+AVERAGE_FRACTION_BITS-1:0] i_avg,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output mea_pkg::t_sample         o_filtered,
    output logic                     o_active,
    output logic                     o_pending
);
    import mea_pkg::*;

    localparam int AW = SAMPLE_W + AVERAGE_FRACTION_BITS;
    localparam int HW = $clog2(RAISE_CONFIRM + 1);
    localparam int LW = $clog2(CLEAR_CONFIRM + 1);
    localparam logic [AW:0] HALF = (AW + 1)'(1) << (AVERAGE_FRACTION_BITS - 1);

    logic            r_flag;
    logic [HW-1:0]   r_high;
    logic [LW-1:0]   r_low;
    logic            r_valid;
    t_sample         r_filtered;
    logic            r_active;
    logic            r_pending;

    logic            accept;
    logic [AW:0]     rnd_sum;
    logic [SAMPLE_W:0] rounded;
    t_sample         filt;
    logic [HW-1:0]   high_inc;
    logic [LW-1:0]   low_inc;
    logic            n_flag;
    logic [HW-1:0]   n_high;
    logic [LW-1:0]   n_low;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Round half up to an integer and saturate.
    always_comb begin
        rnd_sum = {1'b0, i_avg} + HALF;
        rounded = rnd_sum[AW:AVERAGE_FRACTION_BITS];
        filt    = rounded[SAMPLE_W] ? '1 : rounded[SAMPLE_W-1:0];
    end

    // Alarm: confirm a rise or a fall over consecutive items.
    always_comb begin
        high_inc = r_high + HW'(1);
        low_inc  = r_low + LW'(1);
        n_flag   = r_flag;
        n_high   = '0;
        n_low    = '0;
        if (!r_flag) begin
            if (filt >= i_cfg.threshold) begin
                if (high_inc >= HW'(RAISE_CONFIRM)) begin
                    n_flag = 1'b1;
                end else begin
                    n_high = high_inc;
                end
            end
        end else begin
            if ($signed({1'b0, filt}) <= i_cfg.clear_level) begin
                if (low_inc >= LW'(CLEAR_CONFIRM)) begin
                    n_flag = 1'b0;
                end else begin
                    n_low = low_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_filtered <= filt;
            r_active   <= n_flag;
            r_pending  <= !n_flag && (n_high != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= 1'b0;
            r_high  <= '0;
            r_low   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_flag <= n_flag;
                r_high <= n_high;
                r_low  <= n_low;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_filtered = r_filtered;
    assign o_active   = r_active;
    assign o_pending  = r_pending;

endmodule

`default_nettype wire

// ===== rtl/core/median_ema_alarm_filter_top.sv =====
// Top level of the median filter with exponential average and hysteresis alarm.
//
// Usage: one 12-bit sample enters per item on i_sample; one result item leaves on
// o_result with the rounded average and the alarm flags. The alarm threshold is
// written on i_cfg, which is always ready; a write of zero stores one. Writes are
// to be made only while no item is in flight; the block itself does not enforce this.
// Each sample passes the window stage, median stage, average stage and result
// register in that order before its result item becomes valid.
// Throughput: one item per cycle unless the receiver stalls; each stage holds one item
// and moves it on once the stage after it has room, so all four stages run every cycle.
// The median stage compares every held sample with every other one in parallel.
// Reset (synchronous, active low): the window is empty, the average unseeded, the
// alarm and its run counters cleared and the threshold 2000; all stages are empty.
// When the receiver stalls, the result register holds its item and the earlier
// stages fill up one by one; i_sample.ready drops only once all four are full.
`default_nettype none

module median_ema_alarm_filter_top #(
    parameter int WINDOW_DEPTH          = mea_pkg::WINDOW_DEPTH,
    parameter int RAISE_CONFIRM         = mea_pkg::RAISE_CONFIRM,
    parameter int CLEAR_CONFIRM         = mea_pkg::CLEAR_CONFIRM,
    parameter int AVERAGE_FRACTION_BITS = mea_pkg::AVERAGE_FRACTION_BITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mea_sample_if.sink   i_sample,
    mea_cfg_if.sink      i_cfg,
    mea_result_if.source o_result
);
    import mea_pkg::*;

    localparam int AW = SAMPLE_W + AVERAGE_FRACTION_BITS;

    t_alarm_cfg r_cfg;

    logic       med_valid;
    logic       med_ready;
    t_sample    median;
    logic       avg_valid;
    logic       avg_ready;
    logic [AW-1:0] avg;
    t_sample    n_threshold;

    // Threshold register; the clear level is derived at write time.
    assign i_cfg.ready = 1'b1;
    assign n_threshold = mea_sat_threshold(i_cfg.alarm_threshold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= t_sample'(THRESHOLD_RESET);
            r_cfg.clear_level <= CLEAR_LEVEL_RESET;
        end else if (i_cfg.valid) begin
            r_cfg.threshold   <= n_threshold;
            r_cfg.clear_level <= mea_clear_level(n_threshold);
        end
    end

    // Window and median.
    mea_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_sample.valid),
        .o_ready  (i_sample.ready),
        .i_sample (i_sample.raw_sample),
        .o_valid  (med_valid),
        .i_ready  (med_ready),
        .o_median (median)
    );

    // Exponential average.
    mea_ema #(
        .AVERAGE_FRACTION_BITS(AVERAGE_FRACTION_BITS)
    ) u_ema (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (med_valid),
        .o_ready  (med_ready),
        .i_median (median),
        .o_valid  (avg_valid),
        .i_ready  (avg_ready),
        .o_avg    (avg)
    );

    // Rounding, alarm and result register.
    mea_alarm #(
        .AVERAGE_FRACTION_BITS(AVERAGE_FRACTION_BITS),
        .RAISE_CONFIRM        (RAISE_CONFIRM),
        .CLEAR_CONFIRM        (CLEAR_CONFIRM)
    ) u_alarm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (avg_valid),
        .o_ready    (avg_ready),
        .i_avg      (avg),
        .o_valid    (o_result.valid),
        .i_ready    (o_result.ready),
        .o_filtered (o_result.filtered_value),
        .o_active   (o_result.alarm_active),
        .o_pending  (o_result.alarm_pending)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mea_checker.sv =====
// Port-level checker of the filter and its bind to the top level.
`default_nettype none

module mea_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_cfg_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic [mea_pkg::SAMPLE_W-1:0] i_out_filtered,
    input wire logic i_out_active,
    input wire logic i_out_pending
);
    // Reset empties the result register.
    property p_reset_empty;
        @(posedge i_clk) !i_rst_n |=> !i_out_valid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("result valid after reset");

    // A stalled result item holds.
    property p_stall_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_filtered)
            && $stable(i_out_active) && $stable(i_out_pending);
    endproperty
    a_stall_hold: assert property (p_stall_hold)
        else $error("stalled result item changed");

    // A pending rise is only reported while the alarm is off.
    property p_pending_excl;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_out_valid |-> !(i_out_active && i_out_pending);
    endproperty
    a_pending_excl: assert property (p_pending_excl)
        else $error("alarm active and pending together");

    // The configuration channel never blocks.
    property p_cfg_ready;
        @(posedge i_clk) disable iff (!i_rst_n) i_cfg_ready;
    endproperty
    a_cfg_ready: assert property (p_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind median_ema_alarm_filter_top mea_checker u_mea_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_ready    (i_cfg.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_filtered (o_result.filtered_value),
    .i_out_active   (o_result.alarm_active),
    .i_out_pending  (o_result.alarm_pending)
);

`default_nettype wire

// ===== test/tb.sv =====
// Testbench of the median filter with exponential average and hysteresis alarm.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mea_pkg::*;

    localparam int FB    = AVERAGE_FRACTION_BITS;
    localparam int AVG_W = SAMPLE_W + FB;
    localparam int ACC_W = AVG_W + 3;
    localparam int SETTLE_CYCLES = 4;
    localparam int BLOCK_ITEMS   = 30;
    localparam int BLOCKS_PER_PHASE = 5;
    localparam int PHASES = 3;

    // One result item as the filter should produce it.
    typedef struct packed {
        t_sample filtered_value;
        logic    alarm_active;
        logic    alarm_pending;
    } filter_result_t;

    // Shapes of the random sample sequences.
    typedef enum int {
        SEG_ABOVE,
        SEG_BELOW,
        SEG_EDGE,
        SEG_NOISE
    } segment_kind_t;

    // Tracks the filter state and holds the results expected from it.
    class filter_scoreboard;
        t_sample        threshold;
        t_sample        window [WINDOW_DEPTH];
        int unsigned    fill;
        logic [AVG_W-1:0] average;
        bit             seeded;
        bit             alarm;
        int unsigned    high_run;
        int unsigned    low_run;
        filter_result_t expected_q[$];
        int unsigned    mismatches;

        function new();
            threshold  = t_sample'(THRESHOLD_RESET);
            foreach (window[i]) window[i] = '0;
            fill       = 0;
            average    = '0;
            seeded     = 0;
            alarm      = 0;
            high_run   = 0;
            low_run    = 0;
            mismatches = 0;
        endfunction

        function void set_threshold(t_sample value);
            threshold = (value == '0) ? t_sample'(1) : value;
        endfunction

        // Level at or below which the alarm counts towards clearing; may be negative.
        function int clear_level();
            int hyst;
            hyst = int'(threshold) * 8 / 100;
            if (hyst < HYST_MIN) hyst = HYST_MIN;
            if (hyst > HYST_MAX) hyst = HYST_MAX;
            return int'(threshold) - hyst;
        endfunction

        // Element n/2 of the held samples in ascending order.
        function t_sample window_median();
            t_sample sorted [WINDOW_DEPTH];
            t_sample v;
            int      j;
            for (int i = 0; i < fill; i++) sorted[i] = window[i];
            for (int i = 1; i < fill; i++) begin
                v = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            return sorted[fill / 2];
        endfunction

        // Advances the state by one accepted sample and queues its result.
        function void note_sample(t_sample sample);
            t_sample          med;
            logic [ACC_W-1:0] acc;
            logic [ACC_W-1:0] rounded;
            filter_result_t   res;

            // The oldest sample leaves once the window is full.
            if (fill >= WINDOW_DEPTH) begin
                for (int i = 1; i < WINDOW_DEPTH; i++) window[i-1] = window[i];
                window[WINDOW_DEPTH-1] = sample;
            end else begin
                window[fill] = sample;
                fill++;
            end
            med = window_median();

            // The first median seeds the average; later ones blend in by a quarter.
            if (!seeded) begin
                average = AVG_W'(ACC_W'(med) << FB);
                seeded  = 1;
            end else begin
                acc     = ACC_W'(average) * ACC_W'(3) + (ACC_W'(med) << FB);
                average = AVG_W'(acc >> 2);
            end
            rounded = (ACC_W'(average) + (ACC_W'(1) << (FB - 1))) >> FB;
            res.filtered_value = (rounded > ACC_W'(4095)) ? t_sample'(4095)
                                                          : t_sample'(rounded);

            // Hysteresis alarm with confirmation runs in both directions.
            if (!alarm) begin
                low_run = 0;
                if (res.filtered_value >= threshold) begin
                    high_run++;
                    if (high_run >= RAISE_CONFIRM) begin
                        alarm    = 1;
                        high_run = 0;
                    end
                end else begin
                    high_run = 0;
                end
            end else begin
                high_run = 0;
                if (int'(res.filtered_value) <= clear_level()) begin
                    low_run++;
                    if (low_run >= CLEAR_CONFIRM) begin
                        alarm   = 0;
                        low_run = 0;
                    end
                end else begin
                    low_run = 0;
                end
            end
            res.alarm_active  = alarm;
            res.alarm_pending = !alarm && (high_run > 0);
            expected_q.push_back(res);
        endfunction

        // Compares a result item with the oldest expectation.
        function void check_result(filter_result_t got);
            filter_result_t want;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: filtered=%0d active=%0b pending=%0b",
                             got.filtered_value, got.alarm_active, got.alarm_pending);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (want.filtered_value !== got.filtered_value ||
                want.alarm_active !== got.alarm_active ||
                want.alarm_pending !== got.alarm_pending) begin
                if (mismatches < 10)
                    $display("mismatch: expected filtered=%0d active=%0b pending=%0b, %s%0d %s%0b %s%0b",
                             want.filtered_value, want.alarm_active, want.alarm_pending,
                             "got filtered=", got.filtered_value,
                             "active=", got.alarm_active, "pending=", got.alarm_pending);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mea_sample_if sample_ch ();
    mea_cfg_if    cfg_ch ();
    mea_result_if result_ch ();

    median_ema_alarm_filter_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    filter_scoreboard filter_sb;
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;

    // Free-running clock, 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // The receiver stalls at random.
    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every accepted result item is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            filter_sb.check_result('{result_ch.filtered_value, result_ch.alarm_active,
                                     result_ch.alarm_pending});
        end
    end

    function automatic t_sample clamp_sample(int value);
        if (value < 0) return '0;
        if (value > 4095) return t_sample'(4095);
        return t_sample'(value);
    endfunction

    // Offers one sample, after a random gap, and waits until it is accepted.
    task automatic send_sample(t_sample value);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.raw_sample <= value;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        filter_sb.note_sample(value);
    endtask

    // Waits until every expected result has arrived and the pipeline is empty.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (filter_sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(t_sample value);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.alarm_threshold <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        filter_sb.set_threshold(value);
    endtask

    // Random sequences that dwell above, below or near the alarm levels.
    task automatic send_segments(int unsigned count);
        int unsigned   sent;
        int unsigned   seg_len;
        int unsigned   pick;
        int            level;
        int            thr;
        segment_kind_t kind;
        t_sample       value;
        sent = 0;
        while (sent < count) begin
            thr     = int'(filter_sb.threshold);
            seg_len = $urandom_range(4, 24);
            pick    = $urandom_range(0, 9);
            kind    = (pick < 4) ? SEG_ABOVE : (pick < 8) ? SEG_BELOW :
                      (pick < 9) ? SEG_EDGE : SEG_NOISE;
            case (kind)
                SEG_ABOVE: level = thr + int'($urandom_range(0, 300));
                SEG_BELOW: level = filter_sb.clear_level() - int'($urandom_range(0, 300));
                SEG_EDGE:  level = thr + int'($urandom_range(0, 40)) - 20;
                default:   level = 0;
            endcase
            for (int i = 0; i < seg_len && sent < count; i++) begin
                // Occasional spikes exercise the median.
                if (kind == SEG_NOISE || $urandom_range(0, 9) == 0)
                    value = t_sample'($urandom_range(0, 4095));
                else
                    value = clamp_sample(level + int'($urandom_range(0, 60)) - 30);
                send_sample(value);
                sent++;
            end
        end
    endtask

    // Stimulus and the final verdict.
    initial begin
        int unsigned fixed_levels [10];
        int unsigned blk;
        t_sample     thr;

        fixed_levels = '{2000, 4095, 0, 1, 60, 999, 1000, 1250, 3125, 3200};
        filter_sb = new();
        i_rst_n                = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.raw_sample   = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.alarm_threshold = '0;
        result_ch.ready        = 1'b0;
        send_idle_pct          = 12;
        recv_idle_pct          = 54;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes while the window fills, then a full rise and clear
        // of the alarm at the reset threshold.
        send_sample('0);
        send_sample(t_sample'(4095));
        send_sample('0);
        send_sample(t_sample'(4095));
        repeat (8) send_sample(t_sample'(4095));
        repeat (10) send_sample('0);
        repeat (3) send_sample(t_sample'(THRESHOLD_RESET));

        // Random phases, each a few blocks with a new threshold before each.
        for (int phase = 0; phase < PHASES; phase++) begin
            send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 12 : 0;
            for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
                blk = phase * BLOCKS_PER_PHASE + b;
                thr = (blk < 10) ? t_sample'(fixed_levels[blk])
                                 : t_sample'($urandom_range(0, 4095));
                drain_results();
                write_threshold(thr);
                send_segments(BLOCK_ITEMS);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (filter_sb.mismatches == 0 && filter_sb.outstanding() == 0) begin
            $display("[median_ema_alarm_filter_top] OK");
        end else begin
            $display("[median_ema_alarm_filter_top] ERROR");
        end
        $finish;
    end

    // Safety limit on the run time.
    initial begin
        #2_000_000;
        $display("[median_ema_alarm_filter_top] ERROR");
        $finish;
    end
endmodule
